// ===== rtl/cidf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN ID dispatch filter package
// Shared sizes, status codes and the interface records of the extended cells.
// ----------------------------------------------------------------------------
package cidf_pkg;

    localparam int STD_ENTRIES = 32;
    localparam int EXT_ENTRIES = 16;
    localparam int MAP_DEPTH   = 2048;
    localparam int MAX_RESULTS = 16;

    localparam int STD_ID_W = 11;
    localparam int EXT_ID_W = 29;
    localparam int MAP_IDX_W = 6;
    localparam int INDEX_W  = 5;
    localparam int EMIT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [EXT_ID_W-1:0] EXT_ID_ONES = '1;

    typedef enum logic [2:0] {
        ST_REGISTERED = 3'd0,
        ST_FULL       = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_MATCHED    = 3'd3,
        ST_NO_MATCH   = 3'd4
    } status_t;

    typedef struct packed {
        logic                load;
        logic                shift;
        logic [EXT_ID_W-1:0] q_id;
    } cell_cmd_t;

    typedef struct packed {
        logic                en;
        logic [EXT_ID_W-1:0] id;
        logic [EXT_ID_W-1:0] mask;
    } cell_wr_t;

endpackage

// ===== rtl/cidf_ext_cell.sv =====
// ----------------------------------------------------------------------------
// Extended entry cell
// Holds one extended id and mask, a hit flag loaded by a lookup and shifted
// toward the head of the chain.
// ----------------------------------------------------------------------------
module cidf_ext_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  cidf_pkg::cell_cmd_t cmd,
    input  cidf_pkg::cell_wr_t  wr,
    input  logic                sel,
    input  logic                occupied,
    input  logic                hit_in,
    output logic                hit
);

    logic [cidf_pkg::EXT_ID_W-1:0] id_reg;
    logic [cidf_pkg::EXT_ID_W-1:0] mask_reg;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          match;

    always_ff @(posedge clk)
    begin
        if (wr.en && sel)
        begin
            id_reg   <= wr.id;
            mask_reg <= wr.mask;
        end
    end

    assign match = occupied && (((cmd.q_id ^ id_reg) & mask_reg) == '0);

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.load)
        begin
            hit_next = match;
        end
        else if (cmd.shift)
        begin
            hit_next = hit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/cidf_ext_chain.sv =====
// ----------------------------------------------------------------------------
// Extended entry chain
// Row of extended cells; hit flags move one cell toward the head per shift.
// ----------------------------------------------------------------------------
module cidf_ext_chain
#(
    parameter int EXT_ENTRIES = cidf_pkg::EXT_ENTRIES,
    parameter int CNT_W       = $clog2(EXT_ENTRIES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cidf_pkg::cell_cmd_t cmd,
    input  cidf_pkg::cell_wr_t  wr,
    input  logic [CNT_W-1:0]    entry_count,
    output logic                head_hit,
    output logic                rest_hit
);

    logic [EXT_ENTRIES:0] hit_vec;

    assign hit_vec[EXT_ENTRIES] = 1'b0;

    for (genvar i = 0; i < EXT_ENTRIES; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);

        cidf_ext_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .wr       (wr),
            .sel      (entry_count == CELL_IDX),
            .occupied (CELL_IDX < entry_count),
            .hit_in   (hit_vec[i+1]),
            .hit      (hit_vec[i])
        );
    end

    assign head_hit = hit_vec[0];
    assign rest_hit = |hit_vec[EXT_ENTRIES:1];

endmodule

// ===== rtl/can_id_dispatch_filter.sv =====
// ----------------------------------------------------------------------------
// CAN ID dispatch filter
// Routing table for CAN identifiers: standard direct map, extended cell chain.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser: req_type, id_extended; tdata: ident,
// match_mask). Results leave on m_axis (tdata: status, entry_index; tuser:
// entry_extended; tlast marks the final result of a request).
// One request is handled at a time; s_axis_tready is high only when idle.
// Standard register or lookup: S_STD_RD registers the read of the slot map and
// S_STD_DO decides from it and loads the result register. Extended register:
// S_EXT_REG decides and loads the result register. Extended lookup: all cells
// compare in the accept cycle, then the hit flags shift toward the head one
// cell per cycle, except while a hit at the head waits on a stalled m_axis.
// After reset the slot map is cleared one slot per cycle, with s_axis_tready
// low until all MAP_DEPTH (2048) slots are cleared.
// A stalled m_axis holds the result register and, once a hit reaches the
// head, the scan; a new result is placed as soon as the pending one is taken.
// ----------------------------------------------------------------------------
module can_id_dispatch_filter
#(
    parameter int STD_ENTRIES = cidf_pkg::STD_ENTRIES,
    parameter int EXT_ENTRIES = cidf_pkg::EXT_ENTRIES,
    parameter int MAP_DEPTH   = cidf_pkg::MAP_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // ident[28:0], match_mask[57:29], zero
    input  logic [1:0]  s_axis_tuser,   // req_type[0], id_extended[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // status[2:0], entry_index[7:3]
    output logic [0:0]  m_axis_tuser,   // entry_extended[0]
    output logic        m_axis_tlast
);

    localparam int SLOT_W = $clog2(MAP_DEPTH);
    localparam int SCNT_W = $clog2(STD_ENTRIES + 1);
    localparam int ECNT_W = $clog2(EXT_ENTRIES + 1);
    localparam int EIDX_W = (EXT_ENTRIES > 1) ? $clog2(EXT_ENTRIES) : 1;
    localparam int MW     = cidf_pkg::MAP_IDX_W;
    localparam int IW     = cidf_pkg::INDEX_W;
    localparam int NW     = cidf_pkg::EMIT_W;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_STD_RD   = 6'b000100,
        S_STD_DO   = 6'b001000,
        S_EXT_REG  = 6'b010000,
        S_EXT_SCAN = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [SLOT_W-1:0]             clr_addr_reg, clr_addr_next;
    logic [SCNT_W-1:0]             std_count_reg, std_count_next;
    logic [ECNT_W-1:0]             ext_count_reg, ext_count_next;
    logic [EIDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [NW-1:0]                 n_emit_reg, n_emit_next;
    logic                          req_type_reg;
    logic [cidf_pkg::EXT_ID_W-1:0] ident_reg;
    logic [cidf_pkg::EXT_ID_W-1:0] mask_reg;
    logic [MW:0]                   rdata_reg;
    logic [MW:0]                   slot_mem [MAP_DEPTH];

    logic                          out_valid_reg, out_valid_next;
    cidf_pkg::status_t             out_status_reg, out_status_next;
    logic [IW-1:0]                 out_index_reg, out_index_next;
    logic                          out_ext_reg, out_ext_next;
    logic                          out_last_reg, out_last_next;

    logic                          in_acc;
    logic                          out_free;
    logic                          emit;
    logic                          mem_we;
    logic [SLOT_W-1:0]             mem_waddr;
    logic [MW:0]                   mem_wdata;
    logic                          std_full;
    logic                          ext_full;
    logic                          head_hit;
    logic                          rest_hit;
    logic                          scan_last;
    logic                          cmd_shift;
    cidf_pkg::cell_cmd_t           cmd;
    cidf_pkg::cell_wr_t            wr;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign std_full      = (std_count_reg >= SCNT_W'(STD_ENTRIES));
    assign ext_full      = (ext_count_reg >= ECNT_W'(EXT_ENTRIES));
    assign scan_last     = !rest_hit || (n_emit_reg == NW'(cidf_pkg::MAX_RESULTS - 1));

    assign cmd.load  = in_acc && s_axis_tuser[0] && s_axis_tuser[1];
    assign cmd.shift = cmd_shift;
    assign cmd.q_id  = s_axis_tdata[28:0];
    assign wr.en     = (state_reg == S_EXT_REG) && out_free && !ext_full;
    assign wr.id     = ident_reg;
    assign wr.mask   = (mask_reg == '0) ? cidf_pkg::EXT_ID_ONES : mask_reg;

    cidf_ext_chain
    #(
        .EXT_ENTRIES (EXT_ENTRIES),
        .CNT_W       (ECNT_W)
    )
    u_chain
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .wr          (wr),
        .entry_count (ext_count_reg),
        .head_hit    (head_hit),
        .rest_hit    (rest_hit)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[ident_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_type_reg <= s_axis_tuser[0];
            ident_reg    <= s_axis_tdata[28:0];
            mask_reg     <= s_axis_tdata[57:29];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        std_count_next  = std_count_reg;
        ext_count_next  = ext_count_reg;
        scan_idx_next   = scan_idx_reg;
        n_emit_next     = n_emit_reg;
        emit            = 1'b0;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_ext_next    = out_ext_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = ident_reg[SLOT_W-1:0];
        mem_wdata       = {1'b1, MW'(std_count_reg)};
        cmd_shift       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_W'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!s_axis_tuser[1])
                    begin
                        state_next = S_STD_RD;
                    end
                    else if (!s_axis_tuser[0])
                    begin
                        state_next = S_EXT_REG;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        n_emit_next   = '0;
                        state_next    = S_EXT_SCAN;
                    end
                end
            end
            S_STD_RD:
            begin
                state_next = S_STD_DO;
            end
            S_STD_DO:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_ext_next  = 1'b0;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                    priority if (req_type_reg)
                    begin
                        out_status_next = rdata_reg[MW] ? cidf_pkg::ST_MATCHED
                                                        : cidf_pkg::ST_NO_MATCH;
                        out_index_next  = rdata_reg[MW] ? IW'(rdata_reg[MW-1:0]) : '0;
                    end
                    else if (std_full)
                    begin
                        out_status_next = cidf_pkg::ST_FULL;
                        out_index_next  = '0;
                    end
                    else if (rdata_reg[MW])
                    begin
                        out_status_next = cidf_pkg::ST_DUPLICATE;
                        out_index_next  = IW'(rdata_reg[MW-1:0]);
                    end
                    else
                    begin
                        out_status_next = cidf_pkg::ST_REGISTERED;
                        out_index_next  = IW'(std_count_reg);
                        mem_we          = 1'b1;
                        std_count_next  = std_count_reg + 1'b1;
                    end
                end
            end
            S_EXT_REG:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_ext_next  = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                    if (ext_full)
                    begin
                        out_status_next = cidf_pkg::ST_FULL;
                        out_index_next  = '0;
                    end
                    else
                    begin
                        out_status_next = cidf_pkg::ST_REGISTERED;
                        out_index_next  = IW'(ext_count_reg);
                        ext_count_next  = ext_count_reg + 1'b1;
                    end
                end
            end
            S_EXT_SCAN:
            begin
                priority if (head_hit)
                begin
                    if (out_free)
                    begin
                        emit            = 1'b1;
                        out_ext_next    = 1'b1;
                        out_status_next = cidf_pkg::ST_MATCHED;
                        out_index_next  = IW'(scan_idx_reg);
                        out_last_next   = scan_last;
                        cmd_shift       = 1'b1;
                        scan_idx_next   = scan_idx_reg + 1'b1;
                        n_emit_next     = n_emit_reg + 1'b1;
                        if (scan_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (rest_hit)
                begin
                    cmd_shift     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    if (out_free)
                    begin
                        emit            = 1'b1;
                        out_ext_next    = 1'b1;
                        out_status_next = cidf_pkg::ST_NO_MATCH;
                        out_index_next  = '0;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            std_count_reg <= '0;
            ext_count_reg <= '0;
            scan_idx_reg  <= '0;
            n_emit_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            std_count_reg <= std_count_next;
            ext_count_reg <= ext_count_next;
            scan_idx_reg  <= scan_idx_next;
            n_emit_reg    <= n_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_ext_reg    <= out_ext_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_index_reg, out_status_reg};
    assign m_axis_tuser[0] = out_ext_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule
